### rtl/u8strip_pkg.sv
// Shared types and byte-class constants for the UTF-8 orphan byte stripper.
// Used by u8strip_front, u8strip_queue, u8strip_back and the top level.
// No dependencies.
`default_nettype none

package u8strip_pkg;

    // Byte class boundaries
    localparam logic [7:0] ASCII_END  = 8'h80;  // below: plain ASCII
    localparam logic [7:0] LEAD2_MIN  = 8'hC0;  // two-byte lead start
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;  // three-byte lead start
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;  // four-byte lead start
    localparam logic [7:0] LEAD_END   = 8'hF5;  // at or above: invalid byte
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    // Most data bytes one request can release (lead plus three continuations)
    localparam int MAX_DATA = 4;

    // Work handed from the front to the back: data bytes, then an optional terminator
    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;
        logic [2:0]               n_data;
        logic                     term;
    } job_t;

    // Number of results a job produces (at most five)
    function automatic logic [2:0] job_total(input job_t j);
        job_total = j.n_data + {2'b00, j.term};
    endfunction

endpackage

`default_nettype wire

### rtl/u8strip_front.sv
// Front end: classifies each input byte, tracks the held UTF-8 sequence
// and builds the job of result bytes. Depends on u8strip_pkg.
`default_nettype none

module u8strip_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              final_byte,
    output u8strip_pkg::job_t      job,
    output logic                   push
);

    // Held sequence: bytes carry no reset, only entries below held count are read
    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] hcnt_reg, hcnt_next;
    logic [1:0] need_reg, need_next;
    logic       start_reg, start_next;

    logic       is_cont;
    logic       done;

    assign is_cont = (in_byte & u8strip_pkg::CONT_MASK) == u8strip_pkg::CONT_TAG;

    // Next state and job for the current byte
    always_comb
    begin
        held_next  = held_reg;
        hcnt_next  = hcnt_reg;
        need_next  = need_reg;
        start_next = start_reg;
        job        = '0;
        done       = 1'b0;
        if (start_reg && final_byte)
        begin
            // single-byte buffer: byte passes unchanged, then terminator
            job.data[0] = in_byte;
            job.n_data  = 3'd1;
            job.term    = 1'b1;
            hcnt_next   = 2'd0;
            need_next   = 2'd0;
        end
        else
        begin
            start_next = final_byte;
            if (hcnt_reg != 2'd0)
            begin
                if (is_cont)
                begin
                    done = 1'b1;
                    if (need_reg <= 2'd1)
                    begin
                        // sequence complete: release held bytes plus this one
                        for (int i = 0; i < u8strip_pkg::MAX_DATA - 1; i++)
                        begin
                            if (2'(i) < hcnt_reg)
                                job.data[2'(i)] = held_reg[2'(i)];
                        end
                        job.data[hcnt_reg] = in_byte;
                        job.n_data = {1'b0, hcnt_reg} + 3'd1;
                        hcnt_next  = 2'd0;
                        need_next  = 2'd0;
                    end
                    else if (hcnt_reg < 2'd3)
                    begin
                        held_next[hcnt_reg] = in_byte;
                        hcnt_next           = hcnt_reg + 2'd1;
                        need_next           = need_reg - 2'd1;
                    end
                    else
                    begin
                        hcnt_next = 2'd0;
                        need_next = 2'd0;
                    end
                end
                else
                begin
                    // broken sequence: drop hold, byte handled fresh below
                    hcnt_next = 2'd0;
                    need_next = 2'd0;
                end
            end
            if (!done)
            begin
                if (in_byte < u8strip_pkg::ASCII_END)
                begin
                    job.data[0] = in_byte;
                    job.n_data  = 3'd1;
                end
                else if (in_byte >= u8strip_pkg::LEAD2_MIN && in_byte < u8strip_pkg::LEAD_END)
                begin
                    held_next[0] = in_byte;
                    hcnt_next    = 2'd1;
                    if (in_byte < u8strip_pkg::LEAD3_MIN)
                        need_next = 2'd1;
                    else if (in_byte < u8strip_pkg::LEAD4_MIN)
                        need_next = 2'd2;
                    else
                        need_next = 2'd3;
                end
                // stray continuation and F5-FF: dropped
            end
            if (final_byte)
            begin
                hcnt_next = 2'd0;
                need_next = 2'd0;
                job.term  = 1'b1;
            end
        end
    end

    assign push = accept && (u8strip_pkg::job_total(job) != 3'd0);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg  <= 2'd0;
            need_reg  <= 2'd0;
            start_reg <= 1'b1;
        end
        else if (accept)
        begin
            hcnt_reg  <= hcnt_next;
            need_reg  <= need_next;
            start_reg <= start_next;
        end
    end

    // Held bytes
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    // A held sequence always still waits for at least one continuation
    a_hold_needs: assert property (@(posedge clk) disable iff (!rst_n)
        (hcnt_reg != 2'd0) |-> (need_reg != 2'd0))
        else $error("held sequence with no missing continuation");

    // Final byte always leaves nothing held
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (hcnt_reg == 2'd0))
        else $error("sequence still held after final byte");

endmodule

`default_nettype wire

### rtl/u8strip_queue.sv
// Short job queue between front and back so each side stalls on its own.
// Depends on u8strip_pkg.
`default_nettype none

module u8strip_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire u8strip_pkg::job_t push_job,
    input  wire logic              pop,
    output u8strip_pkg::job_t      head_job,
    output logic                   full,
    output logic                   empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8strip_pkg::job_t slot_reg [DEPTH];
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [AW-1:0]     rptr_reg, rptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = slot_reg[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        if (pop)
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/u8strip_back.sv
// Back end: takes one job from the queue and sends its results out one per
// cycle while out_ready is high, data bytes first, then the terminator. Depends on u8strip_pkg.
`default_nettype none

module u8strip_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire u8strip_pkg::job_t head_job,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   is_terminator,
    output logic                   last_of_run
);

    u8strip_pkg::job_t job_reg;
    logic              busy_reg, busy_next;
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        total;
    logic              at_last;
    logic              take;

    assign total     = u8strip_pkg::job_total(job_reg);
    assign at_last   = (idx_reg == total - 3'd1);
    assign take      = busy_reg && out_ready;
    assign pop       = !empty && (!busy_reg || (take && at_last));

    // Result fields come straight from the working job
    assign out_valid     = busy_reg;
    assign out_byte      = (idx_reg < job_reg.n_data) ? job_reg.data[idx_reg[1:0]] : 8'h00;
    assign is_terminator = job_reg.term && (idx_reg == job_reg.n_data);
    assign last_of_run   = at_last;

    // Sequencing through the job
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
        else if (take && at_last)
            busy_next = 1'b0;
        else if (take)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < total))
        else $error("result index past end of job");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (total != 3'd0))
        else $error("empty job loaded into back end");

endmodule

`default_nettype wire

### rtl/utf8_orphan_byte_stripper.sv
// Top level of the UTF-8 orphan byte stripper: front classifier, job queue
// and result sequencer. Depends on u8strip_pkg, u8strip_front,
// u8strip_queue and u8strip_back.
//
//   Channel  Dir  Handshake             Payload
//   input    in   in_valid / in_ready   in_byte[7:0], final_byte
//   output   out  out_valid / out_ready out_byte[7:0], is_terminator, last_of_run
//
// One input byte is taken per cycle while the job queue has room.
// Each byte yields 0 to 5 results; the back end sends one result per cycle
// while out_ready is high, so a byte with k results holds the output side until all k are taken.
// With the back end idle, a byte's job is written into the queue when the byte
// is accepted, then loaded into the back end's working job, which raises out_valid.
// Reset clears control state only; held sequence bytes are not cleared.
// Output stalls fill the queue (QUEUE_DEPTH jobs), then in_ready drops.
`default_nettype none

module utf8_orphan_byte_stripper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       final_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            is_terminator,
    output logic            last_of_run
);

    u8strip_pkg::job_t new_job;
    u8strip_pkg::job_t head_job;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic              accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    u8strip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .job        (new_job),
        .push       (push)
    );

    u8strip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    u8strip_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

### dv/strip_scoreboard_pkg.sv
// Scoreboard for the UTF-8 orphan byte stripper: predicts kept bytes and
// terminators for each accepted request and checks them against the results.
// Depends on u8strip_pkg for the byte class boundaries.

package strip_scoreboard_pkg;

    // One result of the block as it should appear on the output channel
    typedef struct {
        logic [7:0] data;
        logic       term;
        logic       last;
    } strip_result_t;

    class strip_scoreboard;

        strip_result_t due_results[$];
        int            errors;

        // Shadow of the block's sequence state
        logic [7:0] held [3];
        logic [1:0] held_cnt;
        logic [1:0] missing_conts;
        logic       buf_start;

        function new();
            errors        = 0;
            held_cnt      = 2'd0;
            missing_conts = 2'd0;
            buf_start     = 1'b1;
        endfunction

        function void push_result(logic [7:0] data, logic term);
            strip_result_t r;
            r.data = data;
            r.term = term;
            r.last = 1'b0;
            due_results.push_back(r);
        endfunction

        function void drop_held();
            held_cnt      = 2'd0;
            missing_conts = 2'd0;
        endfunction

        // Work out what one accepted request releases
        function void note_request(logic [7:0] b, logic fin);
            int first;
            bit consumed;
            first    = due_results.size();
            consumed = 1'b0;

            // Single-byte buffer: the byte goes out as it is
            if (buf_start && fin) begin
                push_result(b, 1'b0);
                push_result(8'h00, 1'b1);
                drop_held();
                due_results[due_results.size()-1].last = 1'b1;
                return;
            end
            buf_start = fin;

            // A sequence is open: extend it, complete it or break it
            if (held_cnt != 2'd0) begin
                if ((b & u8strip_pkg::CONT_MASK) == u8strip_pkg::CONT_TAG) begin
                    if (missing_conts <= 2'd1) begin
                        for (int i = 0; i < held_cnt; i++)
                            push_result(held[i], 1'b0);
                        push_result(b, 1'b0);
                        drop_held();
                    end
                    else if (held_cnt < 2'd3) begin
                        held[held_cnt] = b;
                        held_cnt       = held_cnt + 2'd1;
                        missing_conts  = missing_conts - 2'd1;
                    end
                    else begin
                        drop_held();
                    end
                    consumed = 1'b1;
                end
                else begin
                    drop_held();
                end
            end

            // Fresh byte: ASCII passes, a lead opens a sequence, the rest is dropped
            if (!consumed) begin
                if (b < u8strip_pkg::ASCII_END) begin
                    push_result(b, 1'b0);
                end
                else if (b >= u8strip_pkg::LEAD2_MIN && b < u8strip_pkg::LEAD_END) begin
                    held[0]  = b;
                    held_cnt = 2'd1;
                    if (b < u8strip_pkg::LEAD3_MIN)
                        missing_conts = 2'd1;
                    else if (b < u8strip_pkg::LEAD4_MIN)
                        missing_conts = 2'd2;
                    else
                        missing_conts = 2'd3;
                end
            end

            // End of buffer: open sequence is lost, terminator follows
            if (fin) begin
                drop_held();
                push_result(8'h00, 1'b1);
            end

            if (due_results.size() > first)
                due_results[due_results.size()-1].last = 1'b1;
        endfunction

        // Compare one output result with the oldest prediction
        function void check_result(logic [7:0] data, logic term, logic last);
            strip_result_t exp_r;
            if (due_results.size() == 0) begin
                $error("unexpected result: out_byte=%02h is_terminator=%0b last_of_run=%0b",
                       data, term, last);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            if (data !== exp_r.data) begin
                $error("out_byte: expected %02h, got %02h", exp_r.data, data);
                errors++;
            end
            if (term !== exp_r.term) begin
                $error("is_terminator: expected %0b, got %0b", exp_r.term, term);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last_of_run: expected %0b, got %0b", exp_r.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

### dv/tb.sv
// Top-level testbench for utf8_orphan_byte_stripper: drives byte requests
// with random idle and stall bursts and checks every result.
// Depends on u8strip_pkg, strip_scoreboard_pkg and the block's RTL.

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 350;
    localparam int CALM_TAIL       = 60;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       final_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       last_of_run;

    strip_scoreboard_pkg::strip_scoreboard sb = new();
    int              requests_sent;
    bit              idle_on;

    utf8_orphan_byte_stripper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Both channels observed at the same edge: requests first, then results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(in_byte, final_byte);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_byte, is_terminator, last_of_run);
    end

    // Output stall bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // Send one byte request and hold it until accepted
    task automatic send_request(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [7:0] rand_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // One buffer of mostly well-formed text with some noise and broken sequences
    task automatic send_random_buffer();
        logic [7:0] text[$];
        int         units;
        int         kind;
        int         seq_len;
        int         conts;
        units = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
        for (int u = 0; u < units; u++) begin
            kind    = $urandom_range(0, 99);
            seq_len = $urandom_range(2, 4);
            if (kind < 35) begin
                text.push_back(8'($urandom_range(0, 127)));
            end
            else if (kind < 80) begin
                case (seq_len)
                    2:       text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    3:       text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: text.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                endcase
                // well formed most of the time, cut short otherwise
                conts = (kind < 70) ? seq_len - 1 : $urandom_range(0, seq_len - 2);
                for (int c = 0; c < conts; c++)
                    text.push_back(rand_cont());
            end
            else if (kind < 88) begin
                text.push_back(rand_cont());
            end
            else if (kind < 94) begin
                text.push_back(8'($urandom_range(8'hF5, 8'hFF)));
            end
            else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[i])
            send_request(text[i], i == text.size() - 1);
    endtask

    // Directed requests, {final_byte, in_byte}
    logic [8:0] directed_seq[$] = '{
        9'h1FF, 9'h180, 9'h1C3,                 // single-byte buffers
        9'h000, 9'h07F,                         // ASCII extremes
        9'h0C0, 9'h080, 9'h0DF, 9'h0BF,         // two-byte leads, both ends
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // four-byte, highest lead
        9'h0EF, 9'h041,                         // sequence broken by ASCII
        9'h0BF, 9'h0F5, 9'h0FF,                 // stray continuation, invalid bytes
        9'h0F0, 9'h09F, 9'h1E0                  // broken by a lead, lead ends buffer
    };

    initial
    begin
        int target;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        final_byte    = 1'b0;
        requests_sent = 0;
        idle_on       = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_seq[i])
            send_request(directed_seq[i][7:0], directed_seq[i][8]);

        target = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target)
        begin
            if (requests_sent >= target - CALM_TAIL)
                idle_on = 1'b0;
            send_random_buffer();
        end
        in_valid <= 1'b0;

        // Drain, then give the queue time to show any extra result
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("utf8_orphan_byte_stripper regression: pass");
        else
            $display("utf8_orphan_byte_stripper regression: fail");
        $finish;
    end

    // Run time limit
    initial
    begin
        #2_000_000;
        $display("utf8_orphan_byte_stripper regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/u8strip_pkg.sv
rtl/u8strip_front.sv
rtl/u8strip_queue.sv
rtl/u8strip_back.sv
rtl/utf8_orphan_byte_stripper.sv
dv/strip_scoreboard_pkg.sv
dv/tb.sv
